@@ hdl/dbs_pkg.sv @@
// ----------------------------------------------------------------------------
// dbs_pkg
// Shared types and constants for the brush dab spacer: field widths, action
// and register codes, and the segment job passed from front to back.
// ----------------------------------------------------------------------------
package dbs_pkg;

  localparam int CoordW    = 24;
  localparam int FracBits  = 8;
  localparam int MaxDabs   = 64;
  localparam int CountW    = 7;
  localparam int IdxW      = 6;
  localparam int SpacingW  = 20;
  localparam int CarryW    = 32;
  localparam int DeltaW    = 25;
  localparam int MagW      = 24;
  localparam int LenW      = 25;
  localparam int Len2W     = 26;
  localparam int RadW      = 50;
  localparam int DivW      = 51;
  localparam int QuoW      = 25;
  localparam int KW        = 17;

  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_POINT = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic REG_SPACING = 1'b0;
  localparam logic REG_SMUDGE  = 1'b1;

  localparam logic [SpacingW-1:0] MinSpacing = SpacingW'(1 << FracBits);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SQX, S_SQY, S_SUM, S_SQRT, S_CLASS,
    S_PREP, S_DIV, S_STORE, S_FIN, S_PUSH
  } front_state_t;

  typedef enum logic {JOB_TRAIL, JOB_SEG} job_kind_t;

  // One segment (or a trail reset) as the back end needs it.
  typedef struct packed {
    job_kind_t               kind;
    logic [CountW-1:0]       count;
    logic signed [CoordW-1:0] base_x;
    logic signed [CoordW-1:0] base_y;
    logic                    neg_x;
    logic                    neg_y;
    logic [QuoW-1:0]         qx;
    logic [Len2W-1:0]        rx;
    logic [QuoW-1:0]         step_qx;
    logic [Len2W-1:0]        step_rx;
    logic [QuoW-1:0]         qy;
    logic [Len2W-1:0]        ry;
    logic [QuoW-1:0]         step_qy;
    logic [Len2W-1:0]        step_ry;
    logic [Len2W-1:0]        len2;
    logic [QuoW-1:0]         step_k;
    logic [LenW-1:0]         rem_k;
    logic [LenW-1:0]         dabbable;
  } job_t;

endpackage

@@ hdl/dbs_in_if.sv @@
// ----------------------------------------------------------------------------
// dbs_in_if
// Stroke request channel: action and point coordinates.
// ----------------------------------------------------------------------------
interface dbs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic signed [dbs_pkg::CoordW-1:0]    point_x;
  logic signed [dbs_pkg::CoordW-1:0]    point_y;

  modport source (output valid, action, point_x, point_y, input ready);
  modport sink   (input valid, action, point_x, point_y, output ready);
endinterface

@@ hdl/dbs_out_if.sv @@
// ----------------------------------------------------------------------------
// dbs_out_if
// Dab request channel: dab centre, source position, blend factor, last flag.
// ----------------------------------------------------------------------------
interface dbs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dbs_pkg::CoordW-1:0]    dab_x;
  logic signed [dbs_pkg::CoordW-1:0]    dab_y;
  logic signed [dbs_pkg::CoordW-1:0]    source_x;
  logic signed [dbs_pkg::CoordW-1:0]    source_y;
  logic [dbs_pkg::KW-1:0]               blend_factor;
  logic                                 last_dab;

  modport source (output valid, dab_x, dab_y, source_x, source_y, blend_factor,
                  last_dab, input ready);
  modport sink   (input valid, dab_x, dab_y, source_x, source_y, blend_factor,
                  last_dab, output ready);
endinterface

@@ hdl/dbs_front.sv @@
// ----------------------------------------------------------------------------
// dbs_front
// Accepts stroke requests, keeps the stroke state, measures each segment with
// a bit-serial square root and prepares stepping constants with a shared
// restoring divider, then hands a job to the queue.
// ----------------------------------------------------------------------------
module dbs_front (
  input  logic                          clk,
  input  logic                          rst,
  dbs_in_if.sink                        points,
  input  logic [dbs_pkg::SpacingW-1:0]  spacing_cfg,
  output dbs_pkg::job_t                 job,
  output logic                          job_valid,
  input  logic                          job_ready
);
  import dbs_pkg::*;

  localparam logic [2:0] DIV_COUNT  = 3'd0;
  localparam logic [2:0] DIV_KSTEP  = 3'd1;
  localparam logic [2:0] DIV_X0     = 3'd2;
  localparam logic [2:0] DIV_XSTEP  = 3'd3;
  localparam logic [2:0] DIV_Y0     = 3'd4;
  localparam logic [2:0] DIV_YSTEP  = 3'd5;
  localparam logic [4:0] LastIter   = 5'(QuoW - 1);

  front_state_t state, state_next;

  logic [1:0]                act;
  logic signed [CoordW-1:0]  px, py;
  logic                      active;
  logic signed [CoordW-1:0]  prev_x, prev_y;
  logic [CarryW-1:0]         carried;
  logic signed [DeltaW-1:0]  dx, dy;
  logic [RadW-1:0]           sqx, sqy;
  logic [RadW-1:0]           rad, root, bitr;
  logic [4:0]                iter;
  logic [SpacingW-1:0]       first;
  logic [LenW-1:0]           dabbable;
  logic [2:0]                dsel;
  logic [DivW-1:0]           dnum, dsh;
  logic [QuoW-1:0]           dquo;
  logic [CountW-1:0]         count;
  logic [QuoW-1:0]           step_k, qx, step_qx, qy, step_qy;
  logic [LenW-1:0]           rem_k;
  logic [Len2W-1:0]          rx, step_rx, ry, step_ry;

  logic [SpacingW-1:0]       spacing;
  logic [LenW-1:0]           len;
  logic [Len2W-1:0]          len2;
  logic [MagW-1:0]           mag_x, mag_y, mag;
  logic [CarryW:0]           short_sum;
  logic                      short_seg;
  logic [SpacingW-1:0]       mul_a;
  logic [SpacingW+MagW-1:0]  prod;
  logic [DivW-1:0]           sq_try;
  logic [DivW-1:0]           num_sel;
  logic [Len2W-1:0]          den_sel;

  // Derived operands.
  always_comb begin
    spacing   = (spacing_cfg < MinSpacing) ? MinSpacing : spacing_cfg;
    len       = root[LenW-1:0];
    len2      = {len, 1'b0};
    mag_x     = dx[DeltaW-1] ? MagW'(-dx) : MagW'(dx);
    mag_y     = dy[DeltaW-1] ? MagW'(-dy) : MagW'(dy);
    short_sum = (CarryW+1)'(len) + (CarryW+1)'(carried);
    short_seg = short_sum < (CarryW+1)'(spacing);
    sq_try    = DivW'(root) + DivW'(bitr);
  end

  // Divider operand selection.
  always_comb begin
    mag   = (dsel == DIV_X0 || dsel == DIV_XSTEP) ? mag_x : mag_y;
    mul_a = (dsel == DIV_X0 || dsel == DIV_Y0) ? first : spacing;
    prod  = (SpacingW+MagW)'(mul_a) * (SpacingW+MagW)'(mag);
    priority case (dsel)
      DIV_COUNT: begin
        num_sel = DivW'(dabbable);
        den_sel = Len2W'(spacing);
      end
      DIV_KSTEP: begin
        num_sel = DivW'(spacing) << 16;
        den_sel = Len2W'(dabbable);
      end
      DIV_X0, DIV_Y0: begin
        num_sel = (DivW'(prod) << 1) + DivW'(len);
        den_sel = len2;
      end
      default: begin
        num_sel = DivW'(prod) << 1;
        den_sel = len2;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (points.valid) state_next = S_DECODE;
      S_DECODE: begin
        priority case (act)
          ACT_BEGIN: state_next = S_PUSH;
          ACT_POINT: state_next = active ? S_SQX : S_IDLE;
          default:   state_next = S_IDLE;
        endcase
      end
      S_SQX:    state_next = S_SQY;
      S_SQY:    state_next = S_SUM;
      S_SUM:    state_next = S_SQRT;
      S_SQRT:   if (iter == LastIter) state_next = S_CLASS;
      S_CLASS:  state_next = (len == '0 || short_seg) ? S_IDLE : S_PREP;
      S_PREP:   state_next = S_DIV;
      S_DIV:    if (iter == LastIter) state_next = S_STORE;
      S_STORE:  state_next = (dsel == DIV_YSTEP) ? S_FIN : S_PREP;
      S_FIN:    state_next = S_PUSH;
      S_PUSH:   if (job_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Handshake outputs and job fields.
  always_comb begin
    points.ready = (state == S_IDLE);
    job_valid    = (state == S_PUSH);
    job.kind     = (act == ACT_BEGIN) ? JOB_TRAIL : JOB_SEG;
    job.count    = count;
    job.base_x   = (act == ACT_BEGIN) ? px : prev_x;
    job.base_y   = (act == ACT_BEGIN) ? py : prev_y;
    job.neg_x    = dx[DeltaW-1];
    job.neg_y    = dy[DeltaW-1];
    job.qx       = qx;
    job.rx       = rx;
    job.step_qx  = step_qx;
    job.step_rx  = step_rx;
    job.qy       = qy;
    job.ry       = ry;
    job.step_qy  = step_qy;
    job.step_ry  = step_ry;
    job.len2     = len2;
    job.step_k   = step_k;
    job.rem_k    = rem_k;
    job.dabbable = dabbable;
  end

  // Stroke state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      active  <= 1'b0;
      prev_x  <= '0;
      prev_y  <= '0;
      carried <= '0;
    end else begin
      state <= state_next;
      if (state == S_DECODE && (act == ACT_BEGIN || act == ACT_END)) begin
        carried <= '0;
        active  <= (act == ACT_BEGIN);
      end
      if (state == S_CLASS && len != '0 && short_seg) begin
        carried <= short_sum[CarryW-1:0];
        prev_x  <= px;
        prev_y  <= py;
      end
      if (state == S_FIN) begin
        carried <= CarryW'(len) - CarryW'(first)
                 - CarryW'((CountW+SpacingW)'(count - 1'b1) * (CountW+SpacingW)'(spacing));
      end
      if (state == S_PUSH && job_ready) begin
        prev_x <= px;
        prev_y <= py;
      end
    end
  end

  // Segment datapath: square root, divisions and stored quotients.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (points.valid) begin
          act <= points.action;
          px  <= points.point_x;
          py  <= points.point_y;
        end
      end
      S_DECODE: begin
        dx <= DeltaW'(px) - DeltaW'(prev_x);
        dy <= DeltaW'(py) - DeltaW'(prev_y);
      end
      S_SQX: sqx <= RadW'(dx) * RadW'(dx);
      S_SQY: sqy <= RadW'(dy) * RadW'(dy);
      S_SUM: begin
        rad  <= sqx + sqy;
        root <= '0;
        bitr <= RadW'(1) << (RadW - 2);
        iter <= '0;
      end
      S_SQRT: begin
        if (DivW'(rad) >= sq_try) begin
          rad  <= rad - sq_try[RadW-1:0];
          root <= (root >> 1) + bitr;
        end else begin
          root <= root >> 1;
        end
        bitr <= bitr >> 2;
        iter <= iter + 1'b1;
      end
      S_CLASS: begin
        first    <= (carried >= CarryW'(spacing)) ? '0 : spacing - carried[SpacingW-1:0];
        dabbable <= len - ((carried >= CarryW'(spacing)) ? LenW'(0)
                           : LenW'(spacing - carried[SpacingW-1:0]));
        dsel     <= DIV_COUNT;
      end
      S_PREP: begin
        dnum <= num_sel;
        dsh  <= DivW'(den_sel) << (QuoW - 1);
        dquo <= '0;
        iter <= '0;
      end
      S_DIV: begin
        if (dnum >= dsh) begin
          dnum <= dnum - dsh;
          dquo <= {dquo[QuoW-2:0], 1'b1};
        end else begin
          dquo <= {dquo[QuoW-2:0], 1'b0};
        end
        dsh  <= dsh >> 1;
        iter <= iter + 1'b1;
      end
      S_STORE: begin
        priority case (dsel)
          DIV_COUNT: count <= (dquo >= QuoW'(MaxDabs)) ? CountW'(MaxDabs)
                                                       : CountW'(dquo) + 1'b1;
          DIV_KSTEP: begin
            step_k <= dquo;
            rem_k  <= dnum[LenW-1:0];
          end
          DIV_X0: begin
            qx <= dquo;
            rx <= dnum[Len2W-1:0];
          end
          DIV_XSTEP: begin
            step_qx <= dquo;
            step_rx <= dnum[Len2W-1:0];
          end
          DIV_Y0: begin
            qy <= dquo;
            ry <= dnum[Len2W-1:0];
          end
          default: begin
            step_qy <= dquo;
            step_ry <= dnum[Len2W-1:0];
          end
        endcase
        dsel <= dsel + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/dbs_queue.sv @@
// ----------------------------------------------------------------------------
// dbs_queue
// Two-entry job queue between the front and the back end.
// ----------------------------------------------------------------------------
module dbs_queue (
  input  logic          clk,
  input  logic          rst,
  input  dbs_pkg::job_t push_job,
  input  logic          push_valid,
  output logic          push_ready,
  output dbs_pkg::job_t pop_job,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import dbs_pkg::*;

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push, pop;

  // Handshakes.
  always_comb begin
    push_ready = (fill != 2'd2);
    pop_valid  = (fill != 2'd0);
    pop_job    = slots[rd_ptr];
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

@@ hdl/dbs_back.sv @@
// ----------------------------------------------------------------------------
// dbs_back
// Steps along a segment one dab per cycle unless dabs stall, with quotient and
// remainder accumulators; tracks the smudge trail, drives the output register.
// ----------------------------------------------------------------------------
module dbs_back (
  input  logic          clk,
  input  logic          rst,
  input  dbs_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  input  logic          smudge,
  dbs_out_if.source     dabs
);
  import dbs_pkg::*;

  job_t                      cur;
  logic                      busy;
  logic [IdxW-1:0]           idx;
  logic [KW-1:0]             kq;
  logic [LenW-1:0]           kr;
  logic signed [CoordW-1:0]  trail_x, trail_y;
  logic                      fire;
  logic                      is_last;
  logic signed [CoordW-1:0]  pos_x, pos_y;
  logic [Len2W:0]            sum_rx, sum_ry;
  logic [LenW:0]             sum_rk;

  // Current dab and the accumulator sums for the next one.
  always_comb begin
    job_ready = !busy;
    fire      = busy && (!dabs.valid || dabs.ready);
    is_last   = (CountW'(idx) + 1'b1) == cur.count;
    pos_x     = cur.base_x + (cur.neg_x ? -CoordW'(cur.qx) : CoordW'(cur.qx));
    pos_y     = cur.base_y + (cur.neg_y ? -CoordW'(cur.qy) : CoordW'(cur.qy));
    sum_rx    = (Len2W+1)'(cur.rx) + (Len2W+1)'(cur.step_rx);
    sum_ry    = (Len2W+1)'(cur.ry) + (Len2W+1)'(cur.step_ry);
    sum_rk    = (LenW+1)'(kr) + (LenW+1)'(cur.rem_k);
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      dabs.valid <= 1'b0;
      trail_x    <= '0;
      trail_y    <= '0;
    end else begin
      if (fire) dabs.valid <= 1'b1;
      else if (dabs.ready) dabs.valid <= 1'b0;
      if (job_valid && !busy) begin
        if (job.kind == JOB_TRAIL) begin
          trail_x <= job.base_x;
          trail_y <= job.base_y;
        end else begin
          busy <= 1'b1;
        end
      end else if (fire && is_last) begin
        busy <= 1'b0;
      end
      if (fire && smudge) begin
        trail_x <= pos_x;
        trail_y <= pos_y;
      end
    end
  end

  // Stepping accumulators and output payload.
  always_ff @(posedge clk) begin
    if (job_valid && !busy) begin
      cur <= job;
      idx <= '0;
      kq  <= '0;
      kr  <= '0;
    end else if (fire) begin
      dabs.dab_x        <= pos_x;
      dabs.dab_y        <= pos_y;
      dabs.source_x     <= smudge ? trail_x : pos_x;
      dabs.source_y     <= smudge ? trail_y : pos_y;
      dabs.blend_factor <= kq;
      dabs.last_dab     <= is_last;
      idx <= idx + 1'b1;
      if (sum_rx >= (Len2W+1)'(cur.len2)) begin
        cur.rx <= Len2W'(sum_rx - (Len2W+1)'(cur.len2));
        cur.qx <= cur.qx + cur.step_qx + 1'b1;
      end else begin
        cur.rx <= Len2W'(sum_rx);
        cur.qx <= cur.qx + cur.step_qx;
      end
      if (sum_ry >= (Len2W+1)'(cur.len2)) begin
        cur.ry <= Len2W'(sum_ry - (Len2W+1)'(cur.len2));
        cur.qy <= cur.qy + cur.step_qy + 1'b1;
      end else begin
        cur.ry <= Len2W'(sum_ry);
        cur.qy <= cur.qy + cur.step_qy;
      end
      // Blend factor: quotient step plus a carry from the running remainder.
      if (sum_rk >= (LenW+1)'(cur.dabbable)) begin
        kr <= LenW'(sum_rk - (LenW+1)'(cur.dabbable));
        kq <= kq + cur.step_k[KW-1:0] + 1'b1;
      end else begin
        kr <= LenW'(sum_rk);
        kq <= kq + cur.step_k[KW-1:0];
      end
    end
  end

endmodule

@@ hdl/brush_dab_spacer.sv @@
// ----------------------------------------------------------------------------
// brush_dab_spacer
// Places brush dabs at even spacing along a pen stroke.
//
//   channel   dir  contents
//   points    in   action, point_x, point_y
//   dabs      out  dab_x, dab_y, source_x, source_y, blend_factor, last_dab
//   cfg       in   cfg_write, cfg_index, cfg_data (dab_spacing, smudge_mode)
//
// A stroke point that yields dabs holds the front from its acceptance to the
// next acceptance while 25 square-root steps and six divisions run on the
// shared restoring divider. A zero-length or short segment frees the front
// after its square root; begin, end and ignored requests need neither. Dabs
// then leave at one per cycle from the back end, unless the dab output stalls,
// while the front works on the next request.
// Reset is synchronous and clears the stroke state and the configuration registers.
// Either side may stall; the job queue decouples the two halves.
// ----------------------------------------------------------------------------
module brush_dab_spacer (
  input  logic                          clk,
  input  logic                          rst,
  dbs_in_if.sink                        points,
  dbs_out_if.source                     dabs,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [dbs_pkg::SpacingW-1:0]  cfg_data
);
  import dbs_pkg::*;

  logic [SpacingW-1:0] dab_spacing;
  logic                smudge_mode;
  job_t                front_job, back_job;
  logic                front_valid, front_ready, back_valid, back_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dab_spacing <= MinSpacing;
      smudge_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SPACING: dab_spacing <= cfg_data;
        REG_SMUDGE:  smudge_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dbs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .points      (points),
    .spacing_cfg (dab_spacing),
    .job         (front_job),
    .job_valid   (front_valid),
    .job_ready   (front_ready)
  );

  dbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_job    (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  dbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .smudge    (smudge_mode),
    .dabs      (dabs)
  );

endmodule
